// File: rtl/core/scd_pkg.sv
// scd_pkg: shared types, command codes and helpers for the sump command decoder
// no dependencies; imported by scd_decoder and sump_command_decoder

package scd_pkg;

    localparam int BUFFER_DEPTH = 8192;
    localparam int COUNT_W      = 14;
    localparam int DIV_W        = 24;
    localparam int DIV_MIN      = 11;

    // short command codes
    localparam logic [7:0] CMD_RESET    = 8'h00;
    localparam logic [7:0] CMD_ARM      = 8'h01;
    localparam logic [7:0] CMD_QUERY    = 8'h02;
    localparam logic [7:0] CMD_SELFTEST = 8'h03;
    localparam logic [7:0] CMD_META     = 8'h04;

    // extended command codes, four argument bytes follow
    localparam logic [7:0] CMD_DIVIDER  = 8'h80;
    localparam logic [7:0] CMD_COUNTS   = 8'h81;
    localparam logic [7:0] CMD_FLAGS    = 8'h82;
    localparam logic [7:0] CMD_TRIG_MSK = 8'hC0;
    localparam logic [7:0] CMD_TRIG_VAL = 8'hC1;
    localparam logic [7:0] CMD_TRIG_CFG = 8'hC2;

    localparam int RLE_BIT = 6;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ARM     = 3'd1,
        EV_QUERY   = 3'd2,
        EV_META    = 3'd3,
        EV_APPLIED = 3'd4,
        EV_BAD_DIV = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        PH_CMD  = 3'd0,
        PH_ARG0 = 3'd1,
        PH_ARG1 = 3'd2,
        PH_ARG2 = 3'd3,
        PH_ARG3 = 3'd4
    } phase_t;

    typedef struct packed {
        event_t             evt;
        logic [7:0]         mask;
        logic [7:0]         level;
        logic [DIV_W-1:0]   divider;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] after;
        logic               rle;
    } result_t;

    // 4*(n+1), saturated at the buffer depth
    function automatic logic [COUNT_W-1:0] count_from(input logic [7:0] lo,
                                                       input logic [7:0] hi);
        logic [18:0] n;
        logic [18:0] depth;
        n     = {1'b0, hi, lo, 2'b00} + 19'd4;
        depth = 19'(BUFFER_DEPTH);
        if (n > depth)
        begin
            n = depth;
        end
        return n[COUNT_W-1:0];
    endfunction

endpackage

// File: rtl/core/sump_command_decoder.sv
// sump_command_decoder: top level with input register, decoder and result register
// depends on scd_pkg and scd_decoder
//
//  channel  signals                              direction  payload
//  in       in_valid, in_stall, rx_byte          host->blk  one received byte
//  out      out_valid, out_stall, event_res ...  blk->sink  event and current settings
//
// every byte gives one result; a byte is held in the input register and is then decoded
// into the result register when out is ready, and that register drives the outputs
// one byte per cycle sustained while out is not stalled, set by the single decode stage
// reset clears the protocol phase and loads the default settings
// a stall on out holds the result; the input register still takes a byte while empty

module sump_command_decoder
    import scd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         event_res,
    output logic [7:0]         trigger_mask,
    output logic [7:0]         trigger_level,
    output logic [23:0]        clock_divider,
    output logic [13:0]        samples_total,
    output logic [13:0]        samples_after,
    output logic               rle_on
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    dec_res;
    logic       out_ready;
    logic       fire;
    logic       in_take;

    assign out_ready = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;
    assign fire      = s1_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (fire)
        begin
            out_reg <= dec_res;
        end
    end

    scd_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (s1_byte_reg),
        .res     (dec_res)
    );

    assign out_valid     = out_valid_reg;
    assign event_res     = out_reg.evt;
    assign trigger_mask  = out_reg.mask;
    assign trigger_level = out_reg.level;
    assign clock_divider = out_reg.divider;
    assign samples_total = out_reg.total;
    assign samples_after = out_reg.after;
    assign rle_on        = out_reg.rle;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with free space in pipeline");

    a_fire_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("decoded byte did not reach result register");

endmodule

// File: rtl/core/scd_decoder.sv
// scd_decoder: protocol state, argument bytes and stored settings
// depends on scd_pkg; one byte is decoded whenever fire is high

module scd_decoder
    import scd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    output result_t    res
);

    phase_t             phase_reg, phase_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [7:0]         arg_reg [4];
    logic [7:0]         arg_next [4];
    logic [7:0]         mask_reg, mask_next;
    logic [7:0]         level_reg, level_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] after_reg, after_next;
    logic               rle_reg, rle_next;
    event_t             evt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMD;
            cmd_reg   <= 8'h00;
            for (int i = 0; i < 4; i++)
            begin
                arg_reg[i] <= 8'h00;
            end
            mask_reg  <= 8'h00;
            level_reg <= 8'h00;
            div_reg   <= DIV_W'(DIV_MIN);
            total_reg <= COUNT_W'(BUFFER_DEPTH);
            after_reg <= '0;
            rle_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            for (int i = 0; i < 4; i++)
            begin
                arg_reg[i] <= arg_next[i];
            end
            mask_reg  <= mask_next;
            level_reg <= level_next;
            div_reg   <= div_next;
            total_reg <= total_next;
            after_reg <= after_next;
            rle_reg   <= rle_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        for (int i = 0; i < 4; i++)
        begin
            arg_next[i] = arg_reg[i];
        end
        mask_next  = mask_reg;
        level_next = level_reg;
        div_next   = div_reg;
        total_next = total_reg;
        after_next = after_reg;
        rle_next   = rle_reg;
        evt        = EV_NONE;

        unique case (phase_reg)
            PH_CMD:
            begin
                cmd_next = rx_byte;
                unique case (rx_byte)
                    CMD_ARM:   evt = EV_ARM;
                    CMD_QUERY: evt = EV_QUERY;
                    CMD_META:  evt = EV_META;
                    CMD_DIVIDER, CMD_COUNTS, CMD_FLAGS,
                    CMD_TRIG_MSK, CMD_TRIG_VAL, CMD_TRIG_CFG:
                        phase_next = PH_ARG0;
                    // reset and self test change nothing
                    default: ;
                endcase
            end
            PH_ARG0:
            begin
                arg_next[0] = rx_byte;
                phase_next  = PH_ARG1;
            end
            PH_ARG1:
            begin
                arg_next[1] = rx_byte;
                phase_next  = PH_ARG2;
            end
            PH_ARG2:
            begin
                arg_next[2] = rx_byte;
                phase_next  = PH_ARG3;
            end
            PH_ARG3:
            begin
                arg_next[3] = rx_byte;
                phase_next  = PH_CMD;
                evt         = EV_APPLIED;
                unique case (cmd_reg)
                    CMD_TRIG_MSK: mask_next  = arg_reg[0];
                    CMD_TRIG_VAL: level_next = arg_reg[0];
                    CMD_TRIG_CFG: ;
                    CMD_DIVIDER:
                    begin
                        div_next = {arg_reg[2], arg_reg[1], arg_reg[0]};
                        if (div_next < DIV_W'(DIV_MIN) || div_next[DIV_W-1:16] != '0)
                        begin
                            evt = EV_BAD_DIV;
                        end
                    end
                    CMD_COUNTS:
                    begin
                        total_next = count_from(arg_reg[0], arg_reg[1]);
                        after_next = count_from(arg_reg[2], rx_byte);
                    end
                    CMD_FLAGS: rle_next = arg_reg[1][RLE_BIT];
                    default:   evt = EV_NONE;
                endcase
            end
            default: phase_next = PH_CMD;
        endcase

        res.evt     = evt;
        res.mask    = mask_next;
        res.level   = level_next;
        res.divider = div_next;
        res.total   = total_next;
        res.after   = after_next;
        res.rle     = rle_next;
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CMD || phase_reg == PH_ARG0 || phase_reg == PH_ARG1 ||
        phase_reg == PH_ARG2 || phase_reg == PH_ARG3)
        else $error("decoder phase out of range");

    a_apply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (evt == EV_APPLIED || evt == EV_BAD_DIV) |-> phase_reg == PH_ARG3)
        else $error("setting applied before last argument byte");

    a_bad_div: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && evt == EV_BAD_DIV) |=> (div_reg < DIV_W'(DIV_MIN) || div_reg[DIV_W-1:16] != '0))
        else $error("divider rejected but stored value in range");

    a_cmd_events: assert property (@(posedge clk) disable iff (!rst_n)
        (evt == EV_ARM || evt == EV_QUERY || evt == EV_META) |-> phase_reg == PH_CMD)
        else $error("short command event outside command phase");

endmodule
